// ----- rtl/core/hsv_to_rgb_converter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// HSV to RGB converter: assertion macros
// Shared helpers for the concurrent checks in the converter RTL.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Check a same-cycle implication.
`define HSV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication whose consequent starts in the next cycle.
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, level format and hue sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

   localparam int unsigned COMP_W   = 8;   // every input and output component
   localparam int unsigned HUE6_W   = 11;  // hue times six
   localparam int unsigned SECTOR_W = 3;
   localparam int unsigned LEVEL_W  = 24;  // level numerator over 2^24
   localparam int unsigned FACTOR_W = 17;  // 65536 minus a product

   typedef logic [SECTOR_W-1:0] sector_type;

   // hue sectors, named by the hue range they span
   localparam sector_type SECTOR_RED_YELLOW    = 3'd0;
   localparam sector_type SECTOR_YELLOW_GREEN  = 3'd1;
   localparam sector_type SECTOR_GREEN_CYAN    = 3'd2;
   localparam sector_type SECTOR_CYAN_BLUE     = 3'd3;
   localparam sector_type SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SECTOR_MAGENTA_RED   = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/core/hsvrgb_scale.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel scaler
// Multiplies a 24-bit level by 255 and keeps the integer part as 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_scale (
   input  wire logic [hsvrgb_pkg::LEVEL_W-1:0] level,
   output logic      [hsvrgb_pkg::COMP_W-1:0]  chan
);

   localparam int unsigned PROD_W = hsvrgb_pkg::LEVEL_W + hsvrgb_pkg::COMP_W;

   logic [PROD_W-1:0] prod;

   // 255 * x as 256 * x - x
   always_comb begin
      prod = {level, {hsvrgb_pkg::COMP_W{1'b0}}} - {{hsvrgb_pkg::COMP_W{1'b0}}, level};
      chan = prod[PROD_W-1:hsvrgb_pkg::LEVEL_W];
   end

endmodule

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_converter_unit.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Four-stage pipeline turning 8-bit hue, saturation and value into RGB.
// ----------------------------------------------------------------------------
// A beat is taken on every clock edge where start is high and busy is low;
// busy is high only while reset is applied and the cycle after, so the unit
// takes one pixel per clock. Each beat comes back through all stage registers
// as a one-cycle rsp_valid strobe with rsp_red, rsp_green and rsp_blue. The
// receiver cannot hold results off, and none is needed: the pipeline never
// stalls, so a beat in every cycle gives a result in every cycle. The stages
// are hue times six, saturation times the hue fraction, value times the
// level factors with sector selection, and the final scale by 255. Zero
// saturation produces grey through the same path.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsv_to_rgb_converter_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [hsvrgb_pkg::COMP_W-1:0] req_hue,
   input  wire logic [hsvrgb_pkg::COMP_W-1:0] req_saturation,
   input  wire logic [hsvrgb_pkg::COMP_W-1:0] req_brightness,
   output logic                               rsp_valid,
   output logic      [hsvrgb_pkg::COMP_W-1:0] rsp_red,
   output logic      [hsvrgb_pkg::COMP_W-1:0] rsp_green,
   output logic      [hsvrgb_pkg::COMP_W-1:0] rsp_blue
);

   localparam int unsigned CW = hsvrgb_pkg::COMP_W;
   localparam int unsigned LW = hsvrgb_pkg::LEVEL_W;
   localparam int unsigned FW = hsvrgb_pkg::FACTOR_W;

   // control
   logic busy_ff, busy_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic accept;

   // stage 1: sector and fraction
   hsvrgb_pkg::sector_type sector1_ff, sector1_in;
   logic [CW-1:0] frac1_ff, frac1_in;
   logic [CW-1:0] sat1_ff, val1_ff;
   logic [hsvrgb_pkg::HUE6_W-1:0] hue6;

   // stage 2: saturation products
   hsvrgb_pkg::sector_type sector2_ff;
   logic [CW-1:0] sat2_ff, val2_ff;
   logic [2*CW-1:0] sf2_ff, sf2_in;
   logic [FW-1:0]   snf2_ff, snf2_in;

   // stage 3: channel levels
   logic [LW-1:0] red3_ff, red3_in, green3_ff, green3_in, blue3_ff, blue3_in;
   logic [FW-1:0] qfac, tfac;
   logic [CW:0]   pfac;
   logic [CW+FW-1:0] lq_prod, lt_prod;
   logic [2*CW:0]    lp_prod;
   logic [LW-1:0] lv, lp, lq, lt;

   // stage 4: scaled channels
   logic [CW-1:0] red4_ff, green4_ff, blue4_ff;
   logic [CW-1:0] red4_in, green4_in, blue4_in;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // hold busy through reset and the cycle after it
   always_comb begin
      busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
      end
   end

   // stage 1: split hue * 6 into sector and fraction
   always_comb begin
      hue6 = {2'b00, req_hue, 1'b0} + {1'b0, req_hue, 2'b00};
      sector1_in = hue6[hsvrgb_pkg::HUE6_W-1:CW];
      frac1_in   = hue6[CW-1:0];
   end

   always_ff @(posedge clock) begin
      sector1_ff <= sector1_in;
      frac1_ff   <= frac1_in;
      sat1_ff    <= req_saturation;
      val1_ff    <= req_brightness;
   end

   // stage 2: S*F and S*(256-F)
   always_comb begin
      sf2_in  = {{CW{1'b0}}, sat1_ff} * {{CW{1'b0}}, frac1_ff};
      snf2_in = FW'({{(FW-CW){1'b0}}, sat1_ff} * ((FW)'(1 << CW) - {{(FW-CW){1'b0}}, frac1_ff}));
   end

   always_ff @(posedge clock) begin
      sector2_ff <= sector1_ff;
      sat2_ff    <= sat1_ff;
      val2_ff    <= val1_ff;
      sf2_ff     <= sf2_in;
      snf2_ff    <= snf2_in;
   end

   // stage 3: form the levels and route them by sector
   always_comb begin
      qfac    = (FW)'(1 << (2*CW)) - {1'b0, sf2_ff};
      tfac    = (FW)'(1 << (2*CW)) - snf2_ff;
      pfac    = (CW+1)'(1 << CW) - {1'b0, sat2_ff};
      lq_prod = {{FW{1'b0}}, val2_ff} * {{CW{1'b0}}, qfac};
      lt_prod = {{FW{1'b0}}, val2_ff} * {{CW{1'b0}}, tfac};
      lp_prod = {1'b0, {CW{1'b0}}, val2_ff} * {{CW{1'b0}}, pfac};
      lv      = {val2_ff, {(2*CW){1'b0}}};
      lp      = {lp_prod[2*CW-1:0], {CW{1'b0}}};
      lq      = lq_prod[LW-1:0];
      lt      = lt_prod[LW-1:0];
      case (sector2_ff)
         hsvrgb_pkg::SECTOR_RED_YELLOW: begin
            red3_in = lv; green3_in = lt; blue3_in = lp;
         end
         hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
            red3_in = lq; green3_in = lv; blue3_in = lp;
         end
         hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
            red3_in = lp; green3_in = lv; blue3_in = lt;
         end
         hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
            red3_in = lp; green3_in = lq; blue3_in = lv;
         end
         hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            red3_in = lt; green3_in = lp; blue3_in = lv;
         end
         hsvrgb_pkg::SECTOR_MAGENTA_RED: begin
            red3_in = lv; green3_in = lp; blue3_in = lq;
         end
         default: begin
            // unreachable for an 8-bit hue: drive black
            red3_in = '0; green3_in = '0; blue3_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      red3_ff   <= red3_in;
      green3_ff <= green3_in;
      blue3_ff  <= blue3_in;
   end

   // stage 4: scale each level by 255 and drop the fraction
   hsvrgb_scale u_scale_red   (.level(red3_ff),   .chan(red4_in));
   hsvrgb_scale u_scale_green (.level(green3_ff), .chan(green4_in));
   hsvrgb_scale u_scale_blue  (.level(blue3_ff),  .chan(blue4_in));

   always_ff @(posedge clock) begin
      red4_ff   <= red4_in;
      green4_ff <= green4_in;
      blue4_ff  <= blue4_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_red   = red4_ff;
   assign rsp_green = green4_ff;
   assign rsp_blue  = blue4_ff;

   // every accepted beat returns as a later rsp_valid strobe
   `HSV_ASSERT_NEXT(a_latency, clock, reset, accept, ##3 rsp_valid, "beat not returned after four cycles")
   // no result without an earlier accepted beat
   `HSV_ASSERT_NOW(a_no_spurious, clock, reset, rsp_valid, $past(accept, 4), "result without a beat")
   // zero saturation gives grey
   `HSV_ASSERT_NOW(a_grey, clock, reset, rsp_valid && $past(req_saturation == '0, 4), (rsp_red == rsp_green) && (rsp_green == rsp_blue), "grey beat has unequal channels")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter unit testbench
// Drives hue, saturation and value beats into the converter and checks every
// RGB result against an exact integer model of the six-sector conversion.
// ----------------------------------------------------------------------------
// A directed set comes first: component extremes, both sides of every sector
// boundary, grey pixels and alternating bit patterns. Random pixels follow in
// three pacing phases: the sender idles now and then, then often, then never.
// The result side has no back-pressure, so the monitor just takes every
// strobe.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int unsigned CYCLE_LIMIT   = 200000;  // far above the slowest run
   localparam int unsigned DRAIN_CYCLES  = 12;      // pipeline is four deep
   localparam int unsigned RANDOM_PHASE1 = 530;
   localparam int unsigned RANDOM_PHASE2 = 530;
   localparam int unsigned RANDOM_PHASE3 = 540;

   typedef logic [hsvrgb_pkg::COMP_W-1:0] comp_type;

   typedef struct packed {
      comp_type hue;
      comp_type saturation;
      comp_type brightness;
   } hsv_pixel_type;

   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
   } rgb_pixel_type;

   // --------------------------------------------------------------------------
   // Clock, reset and DUT ports; every input starts at a known value
   // --------------------------------------------------------------------------
   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     start          = 1'b0;
   comp_type req_hue        = '0;
   comp_type req_saturation = '0;
   comp_type req_brightness = '0;
   logic     busy;
   logic     rsp_valid;
   comp_type rsp_red;
   comp_type rsp_green;
   comp_type rsp_blue;

   always #2 clock = ~clock;

   hsv_to_rgb_converter_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // --------------------------------------------------------------------------
   // Stimulus and scoreboard state
   // --------------------------------------------------------------------------
   hsv_pixel_type pending_pixels[$];   // waiting to be driven
   rgb_pixel_type expected_rgb[$];     // predicted, waiting for the strobe
   int unsigned sender_idle_pct = 22;
   int unsigned pixels_taken    = 0;
   int unsigned grey_taken      = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;
   int unsigned directed_count  = 0;

   // --------------------------------------------------------------------------
   // Color prediction: exact integer form of the six-sector conversion.
   // Every level is a numerator over 2^24; a channel is (255 * level) >> 24.
   // --------------------------------------------------------------------------
   function automatic comp_type scale_level(int unsigned level);
      longint unsigned prod;
      prod = longint'(level) * 255;
      return comp_type'(prod >> hsvrgb_pkg::LEVEL_W);
   endfunction

   function automatic rgb_pixel_type hsv_to_rgb_predict(hsv_pixel_type px);
      logic [hsvrgb_pkg::HUE6_W-1:0] hue6;
      hsvrgb_pkg::sector_type        sector;
      int unsigned                   frac, sat, val;
      int unsigned                   lvl_v, lvl_p, lvl_q, lvl_t;
      rgb_pixel_type                 rgb;
      hue6   = hsvrgb_pkg::HUE6_W'(px.hue) * hsvrgb_pkg::HUE6_W'(6);
      sector = hue6[hsvrgb_pkg::HUE6_W-1 -: hsvrgb_pkg::SECTOR_W];
      frac   = hue6[hsvrgb_pkg::COMP_W-1:0];
      sat    = px.saturation;
      val    = px.brightness;
      lvl_v  = val * 65536;
      lvl_p  = val * (256 - sat) * 256;
      lvl_q  = val * (65536 - sat * frac);
      lvl_t  = val * (65536 - sat * (256 - frac));
      case (sector)
         hsvrgb_pkg::SECTOR_RED_YELLOW: begin
            rgb = {scale_level(lvl_v), scale_level(lvl_t), scale_level(lvl_p)};
         end
         hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
            rgb = {scale_level(lvl_q), scale_level(lvl_v), scale_level(lvl_p)};
         end
         hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
            rgb = {scale_level(lvl_p), scale_level(lvl_v), scale_level(lvl_t)};
         end
         hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
            rgb = {scale_level(lvl_p), scale_level(lvl_q), scale_level(lvl_v)};
         end
         hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            rgb = {scale_level(lvl_t), scale_level(lvl_p), scale_level(lvl_v)};
         end
         hsvrgb_pkg::SECTOR_MAGENTA_RED: begin
            rgb = {scale_level(lvl_v), scale_level(lvl_p), scale_level(lvl_q)};
         end
         default: begin
            rgb = '0;  // unreachable for an 8-bit hue; black by definition
         end
      endcase
      return rgb;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic queue_pixel(input comp_type h, input comp_type s, input comp_type v);
      hsv_pixel_type px;
      px = '{hue: h, saturation: s, brightness: v};
      pending_pixels.push_back(px);
   endtask

   // Bias each component toward its extremes now and then, otherwise uniform.
   function automatic comp_type random_comp();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end
      return comp_type'($urandom_range(255));
   endfunction

   task automatic queue_random_pixels(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         queue_pixel(random_comp(), random_comp(), random_comp());
      end
   endtask

   // --------------------------------------------------------------------------
   // Driver: hold a beat until it is taken, then advance to the next pixel.
   // The beat is taken at an edge where start is high and busy is low; the
   // prediction is pushed at that same edge.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      hsv_pixel_type taken_px;
      logic          taken;
      taken = start && !busy;
      if (taken) begin
         taken_px = pending_pixels.pop_front();
         expected_rgb.push_back(hsv_to_rgb_predict(taken_px));
         pixels_taken++;
         if (taken_px.saturation == '0) begin
            grey_taken++;
         end
      end
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // hold the current beat until busy drops
      end else if (pending_pixels.size() != 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
         start          <= 1'b1;
         req_hue        <= pending_pixels[0].hue;
         req_saturation <= pending_pixels[0].saturation;
         req_brightness <= pending_pixels[0].brightness;
      end else begin
         start <= 1'b0;
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: take every strobe and compare it with the oldest prediction
   // --------------------------------------------------------------------------
   task automatic check_channel(input string chan, input comp_type want, input comp_type got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      end
   endtask

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset && rsp_valid) begin
         if (expected_rgb.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d",
                     $time, rsp_red, rsp_green, rsp_blue);
         end else begin
            want = expected_rgb.pop_front();
            results_checked++;
            check_channel("red",   want.red,   rsp_red);
            check_channel("green", want.green, rsp_green);
            check_channel("blue",  want.blue,  rsp_blue);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: end a hung run
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels pending and %0d results outstanding",
                  $time, pending_pixels.size(), expected_rgb.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Sequence: reset, directed pixels, three random pacing phases, drain
   // --------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Component extremes: black, saturated red at hue 255, full red, white, zero value.
      queue_pixel(8'd0,   8'd0,   8'd0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd0,   8'd255, 8'd255);
      queue_pixel(8'd255, 8'd0,   8'd255);
      queue_pixel(8'd128, 8'd128, 8'd0);
      // Both sides of each sector boundary, fully saturated; 214, above the last, has lower saturation.
      queue_pixel(8'd42,  8'd255, 8'd255);
      queue_pixel(8'd43,  8'd255, 8'd255);
      queue_pixel(8'd85,  8'd255, 8'd255);
      queue_pixel(8'd86,  8'd255, 8'd255);
      queue_pixel(8'd127, 8'd255, 8'd255);
      queue_pixel(8'd128, 8'd255, 8'd255);
      queue_pixel(8'd170, 8'd255, 8'd255);
      queue_pixel(8'd171, 8'd255, 8'd255);
      queue_pixel(8'd212, 8'd255, 8'd255);
      queue_pixel(8'd213, 8'd255, 8'd255);
      queue_pixel(8'd214, 8'd200, 8'd255);
      // Zero saturation collapses to grey in three different sectors.
      queue_pixel(8'd100, 8'd0,   8'd200);
      queue_pixel(8'd37,  8'd0,   8'd1);
      queue_pixel(8'd230, 8'd0,   8'd128);
      // Small values and alternating bit patterns.
      queue_pixel(8'd1,   8'd1,   8'd1);
      queue_pixel(8'd254, 8'd254, 8'd254);
      queue_pixel(8'hAA,  8'h55,  8'hAA);
      queue_pixel(8'h55,  8'hAA,  8'h55);
      directed_count = pending_pixels.size();

      // Sender idles now and then while the directed set and the first batch run.
      sender_idle_pct = 22;
      queue_random_pixels(RANDOM_PHASE1);
      while (pending_pixels.size() != 0) @(posedge clock);

      sender_idle_pct = 55;
      queue_random_pixels(RANDOM_PHASE2);
      while (pending_pixels.size() != 0) @(posedge clock);

      // Back-to-back beats: one pixel per clock.
      sender_idle_pct = 0;
      queue_random_pixels(RANDOM_PHASE3);
      while (pending_pixels.size() != 0 || expected_rgb.size() != 0) @(posedge clock);

      // Let any stray strobe show up before closing out.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d pixels converted (%0d directed, %0d grey), %0d results checked",
               pixels_taken, directed_count, grey_taken, results_checked);
      $display("Summary: random pixels ran at sender idle rates of 22, 55 and 0 percent");
      if (mismatch_count == 0 && expected_rgb.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
